// File: rtl/fr_pkg.sv
package fr_pkg;

    localparam int MAX_FRAGS_DEF  = 16;
    localparam int SLOT_BYTES_DEF = 153;
    localparam logic [15:0] TIMEOUT_RESET = 16'd10000;

    localparam int ADDR_W = 12;
    localparam int CNT_W  = 5;

    typedef enum logic [1:0] {
        CMD_FRAG    = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_READ    = 2'd2,
        CMD_RELEASE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_DONE       = 3'd0,
        ST_TAKEN      = 3'd1,
        ST_DUP        = 3'd2,
        ST_BADCOUNT   = 3'd3,
        ST_BADLEN     = 3'd4,
        ST_POOLFULL   = 3'd5,
        ST_NOTOKEN    = 3'd6,
        ST_INCOMPLETE = 3'd7
    } status_t;

    // classified item as it travels from front to back
    typedef struct packed {
        cmd_t              cmd;
        logic [7:0]        token;
        logic [7:0]        frag_count;
        logic [7:0]        frag_index;
        logic [7:0]        data_byte;
        logic              end_of_frag;
        logic [ADDR_W-1:0] read_address;
        logic              count_ok;
        logic              is_tail;
    } item_t;

endpackage

// File: rtl/fr_front.sv
module fr_front #(
    parameter int MAX_FRAGS = fr_pkg::MAX_FRAGS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                command,
    input  logic [7:0]                token,
    input  logic [7:0]                frag_count,
    input  logic [7:0]                frag_index,
    input  logic [7:0]                data_byte,
    input  logic                      end_of_frag,
    input  logic [fr_pkg::ADDR_W-1:0] read_address,
    output logic                      q_valid,
    output fr_pkg::item_t             q_item,
    input  logic                      q_pop
);

    fr_pkg::item_t q_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    fr_pkg::item_t item_in;
    logic          push;
    logic          pop;

    always_comb
    begin
        item_in.cmd          = fr_pkg::cmd_t'(command);
        item_in.token        = token;
        item_in.frag_count   = frag_count;
        item_in.frag_index   = frag_index;
        item_in.data_byte    = data_byte;
        item_in.end_of_frag  = end_of_frag;
        item_in.read_address = read_address;
        item_in.count_ok     = (frag_count != 8'd0) && (frag_count <= 8'(MAX_FRAGS))
                               && (frag_index < frag_count);
        item_in.is_tail      = ({1'b0, frag_index} + 9'd1) == {1'b0, frag_count};
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// File: rtl/fr_back.sv
module fr_back #(
    parameter int MAX_FRAGS  = fr_pkg::MAX_FRAGS_DEF,
    parameter int SLOT_BYTES = fr_pkg::SLOT_BYTES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [15:0]               timeout_ticks,
    input  logic                      q_valid,
    input  fr_pkg::item_t             q_item,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [2:0]                status,
    output logic [7:0]                read_data,
    output logic                      complete,
    output logic                      entry_active,
    output logic [fr_pkg::ADDR_W-1:0] total_length,
    output logic [7:0]                held_token
);

    localparam int BUF_BYTES = MAX_FRAGS * SLOT_BYTES;
    localparam int IW        = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
    localparam int AW        = fr_pkg::ADDR_W;
    localparam int CW        = fr_pkg::CNT_W;

    logic [7:0] mem [BUF_BYTES];
    logic [7:0] mem_q_reg;

    logic                 valid_reg, valid_next;
    logic [7:0]           tok_reg, tok_next;
    logic [CW-1:0]        fc_reg, fc_next;
    logic [MAX_FRAGS-1:0] mask_reg, mask_next;
    logic [CW-1:0]        rc_reg, rc_next;
    logic [AW-1:0]        len_reg, len_next;
    logic [15:0]          age_reg, age_next;
    logic [7:0]           pos_reg, pos_next;
    fr_pkg::status_t      ferr_reg, ferr_next;
    logic                 fnew_reg, fnew_next;

    logic            ov_reg;
    fr_pkg::status_t st_reg, st_next;
    logic            cpl_reg, act_reg, rdsel_reg, rdsel_next;
    logic [AW-1:0]   tl_reg;
    logic [7:0]      ht_reg;

    logic            take;
    logic            wr_en, rd_en;
    logic [AW-1:0]   wr_addr;
    logic [IW-1:0]   idx;
    logic [8:0]      flen;
    logic            len_bad, new_eff;
    fr_pkg::status_t err;

    assign q_pop = q_valid && (!ov_reg || !out_stall);
    assign take  = q_pop;
    assign idx   = q_item.frag_index[IW-1:0];
    assign flen  = {1'b0, pos_reg} + 9'd1;
    assign wr_addr = AW'(idx) * AW'(SLOT_BYTES) + AW'(pos_reg);

    always_comb
    begin
        valid_next = valid_reg;
        tok_next   = tok_reg;
        fc_next    = fc_reg;
        mask_next  = mask_reg;
        rc_next    = rc_reg;
        len_next   = len_reg;
        age_next   = age_reg;
        pos_next   = pos_reg;
        ferr_next  = ferr_reg;
        fnew_next  = fnew_reg;
        st_next    = fr_pkg::ST_DONE;
        rdsel_next = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        err        = fr_pkg::ST_DONE;
        new_eff    = fnew_reg;
        len_bad    = 1'b0;

        case (q_item.cmd)
            fr_pkg::CMD_FRAG:
            begin
                if (pos_reg == 8'd0)
                begin
                    new_eff = 1'b0;
                    if (!q_item.count_ok)
                    begin
                        err = fr_pkg::ST_BADCOUNT;
                    end
                    else
                    begin
                        if (valid_reg && age_reg >= timeout_ticks)
                        begin
                            valid_next = 1'b0;
                        end
                        if (!valid_next)
                        begin
                            valid_next = 1'b1;
                            tok_next   = q_item.token;
                            fc_next    = CW'(q_item.frag_count);
                            mask_next  = '0;
                            rc_next    = '0;
                            len_next   = '0;
                            age_next   = '0;
                            new_eff    = 1'b1;
                        end
                        if (q_item.token != tok_next)
                            err = fr_pkg::ST_POOLFULL;
                        else if (q_item.frag_index >= 8'(fc_next))
                            err = fr_pkg::ST_BADLEN;
                        else if (mask_next[idx])
                            err = fr_pkg::ST_DUP;
                    end
                end
                else if (ferr_reg == fr_pkg::ST_DONE)
                begin
                    if (!q_item.count_ok)
                        err = fr_pkg::ST_BADCOUNT;
                    else if (!valid_reg)
                        err = fr_pkg::ST_NOTOKEN;
                    else if (q_item.token != tok_reg)
                        err = fr_pkg::ST_POOLFULL;
                    else if (q_item.frag_index >= 8'(fc_reg))
                        err = fr_pkg::ST_BADLEN;
                    else if (mask_reg[idx])
                        err = fr_pkg::ST_DUP;
                end
                else
                begin
                    err = ferr_reg;
                end

                wr_en = (err == fr_pkg::ST_DONE) && (pos_reg < 8'(SLOT_BYTES));

                if (!q_item.end_of_frag)
                begin
                    st_next   = (err == fr_pkg::ST_DONE) ? fr_pkg::ST_TAKEN : err;
                    pos_next  = (pos_reg == 8'hFF) ? pos_reg : pos_reg + 8'd1;
                    ferr_next = err;
                    fnew_next = new_eff;
                end
                else
                begin
                    len_bad = (flen > 9'(SLOT_BYTES))
                              || ((flen != 9'(SLOT_BYTES)) && !q_item.is_tail);
                    if (err == fr_pkg::ST_BADCOUNT)
                    begin
                        st_next = fr_pkg::ST_BADCOUNT;
                    end
                    else if (len_bad)
                    begin
                        st_next = fr_pkg::ST_BADLEN;
                        if (new_eff)
                        begin
                            valid_next = 1'b0;
                        end
                    end
                    else if (err != fr_pkg::ST_DONE)
                    begin
                        st_next = err;
                    end
                    else
                    begin
                        mask_next      = mask_next;
                        mask_next[idx] = 1'b1;
                        rc_next        = rc_next + CW'(1);
                        len_next       = len_next + AW'(flen);
                        st_next        = fr_pkg::ST_DONE;
                    end
                    pos_next  = 8'd0;
                    ferr_next = fr_pkg::ST_DONE;
                    fnew_next = 1'b0;
                end
            end
            fr_pkg::CMD_TICK:
            begin
                if (valid_reg && age_reg != 16'hFFFF)
                begin
                    age_next = age_reg + 16'd1;
                end
            end
            fr_pkg::CMD_READ:
            begin
                if (!valid_reg || q_item.token != tok_reg)
                    st_next = fr_pkg::ST_NOTOKEN;
                else if (rc_reg != fc_reg)
                    st_next = fr_pkg::ST_INCOMPLETE;
                else if (q_item.read_address >= len_reg
                         || 32'(q_item.read_address) >= BUF_BYTES)
                    st_next = fr_pkg::ST_BADLEN;
                else
                begin
                    rd_en      = 1'b1;
                    rdsel_next = 1'b1;
                end
            end
            fr_pkg::CMD_RELEASE:
            begin
                if (valid_reg && q_item.token == tok_reg)
                    valid_next = 1'b0;
                else
                    st_next = fr_pkg::ST_NOTOKEN;
            end
            default:
            begin
                st_next = fr_pkg::ST_DONE;
            end
        endcase

        // a freed entry reads back as all zero
        if (!valid_next)
        begin
            tok_next  = '0;
            fc_next   = '0;
            mask_next = '0;
            rc_next   = '0;
            len_next  = '0;
            age_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
            fc_reg    <= '0;
            mask_reg  <= '0;
            rc_reg    <= '0;
            len_reg   <= '0;
            age_reg   <= '0;
            pos_reg   <= '0;
            ferr_reg  <= fr_pkg::ST_DONE;
            fnew_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            st_reg    <= fr_pkg::ST_DONE;
            cpl_reg   <= 1'b0;
            act_reg   <= 1'b0;
            tl_reg    <= '0;
            ht_reg    <= '0;
            rdsel_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                valid_reg <= valid_next;
                tok_reg   <= tok_next;
                fc_reg    <= fc_next;
                mask_reg  <= mask_next;
                rc_reg    <= rc_next;
                len_reg   <= len_next;
                age_reg   <= age_next;
                pos_reg   <= pos_next;
                ferr_reg  <= ferr_next;
                fnew_reg  <= fnew_next;
                st_reg    <= st_next;
                cpl_reg   <= valid_next && (rc_next == fc_next);
                act_reg   <= valid_next;
                tl_reg    <= len_next;
                ht_reg    <= tok_next;
                rdsel_reg <= rdsel_next;
                ov_reg    <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && wr_en)
        begin
            mem[wr_addr] <= q_item.data_byte;
        end
        if (take && rd_en)
        begin
            mem_q_reg <= mem[q_item.read_address];
        end
    end

    assign out_valid    = ov_reg;
    assign status       = st_reg;
    assign read_data    = rdsel_reg ? mem_q_reg : 8'd0;
    assign complete     = cpl_reg;
    assign entry_active = act_reg;
    assign total_length = tl_reg;
    assign held_token   = ht_reg;

endmodule

// File: rtl/fragment_reassembler_top.sv
// Path: an accepted item goes through the queue, then the result register, to the output.
// Throughput: 1 item per cycle while the output is not stalled; the back end
//   retires one queued item per cycle, a read uses the buffer's registered read port.
// Reset: asynchronous, active low; clears entry state, queue and result register,
//   timeout_ticks returns to 10000. The merge buffer is not cleared.
module fragment_reassembler_top #(
    parameter int MAX_FRAGS  = fr_pkg::MAX_FRAGS_DEF,
    parameter int SLOT_BYTES = fr_pkg::SLOT_BYTES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration: timeout_ticks
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [15:0]               cfg_data,
    // item input
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                command,
    input  logic [7:0]                token,
    input  logic [7:0]                frag_count,
    input  logic [7:0]                frag_index,
    input  logic [7:0]                data_byte,
    input  logic                      end_of_frag,
    input  logic [fr_pkg::ADDR_W-1:0] read_address,
    // result output
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [2:0]                status,
    output logic [7:0]                read_data,
    output logic                      complete,
    output logic                      entry_active,
    output logic [fr_pkg::ADDR_W-1:0] total_length,
    output logic [7:0]                held_token
);

    logic [15:0]   timeout_reg;
    logic          q_valid;
    logic          q_pop;
    fr_pkg::item_t q_item;

    // config register always writable; writes must come only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= fr_pkg::TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            timeout_reg <= cfg_data;
        end
    end

    // front: takes items, classifies count and tail, queues two deep
    fr_front #(
        .MAX_FRAGS (MAX_FRAGS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .token        (token),
        .frag_count   (frag_count),
        .frag_index   (frag_index),
        .data_byte    (data_byte),
        .end_of_frag  (end_of_frag),
        .read_address (read_address),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    // back: entry state, merge buffer, result register
    fr_back #(
        .MAX_FRAGS  (MAX_FRAGS),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .timeout_ticks (timeout_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .read_data     (read_data),
        .complete      (complete),
        .entry_active  (entry_active),
        .total_length  (total_length),
        .held_token    (held_token)
    );

    // complete only for a held entry
    a_cpl_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && complete |-> entry_active)
        else $error("complete without entry");

    // no entry means zero length and token
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !entry_active |-> (total_length == '0) && (held_token == 8'd0))
        else $error("stale entry fields");

    // read data only on a successful read
    a_rd_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (read_data != 8'd0) |-> (status == fr_pkg::ST_DONE) && complete)
        else $error("read data with error status");

endmodule

// File: tb/fr_checker.sv
module fr_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  token,
    input  logic [7:0]  frag_count,
    input  logic [7:0]  frag_index,
    input  logic [7:0]  data_byte,
    input  logic        end_of_frag,
    input  logic [11:0] read_address,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  status,
    input  logic [7:0]  read_data,
    input  logic        complete,
    input  logic        entry_active,
    input  logic [11:0] total_length,
    input  logic [7:0]  held_token,
    output int          err_count,
    output int          pending,
    output int          n_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT = 153;
    localparam int NFR  = 16;
    localparam int BUFN = NFR * SLOT;

    typedef struct packed {
        logic [2:0]  st;
        logic [7:0]  rd;
        logic        cmpl;
        logic        act;
        logic [11:0] tlen;
        logic [7:0]  tok;
    } reply_t;

    reply_t replies_q[$];

    logic [15:0] tmo;
    logic        e_valid;
    logic [7:0]  e_tok;
    logic [4:0]  e_cnt;
    logic [15:0] rx_mask;
    logic [4:0]  rx_cnt;
    logic [11:0] c_len;
    logic [15:0] age;
    logic [7:0]  mbuf [BUFN];
    logic [7:0]  bpos;
    logic [2:0]  ferr;
    logic        fnew;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp_v);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
        err_count++;
    endtask

    task automatic clear_entry();
        e_valid = 0; e_tok = 0; e_cnt = 0; rx_mask = 0; rx_cnt = 0; c_len = 0; age = 0;
    endtask

    function automatic bit cnt_ok(input int c, input int i);
        return c >= 1 && c <= NFR && i < c;
    endfunction

    function automatic logic [2:0] match_entry(input logic [7:0] t, input int i);
        if (!e_valid) return fr_pkg::ST_NOTOKEN;
        if (t != e_tok) return fr_pkg::ST_POOLFULL;
        if (i >= e_cnt || i >= 16) return fr_pkg::ST_BADLEN;
        if (rx_mask[i]) return fr_pkg::ST_DUP;
        return fr_pkg::ST_DONE;
    endfunction

    task automatic frag_byte(input logic [7:0] t, input int c, input int i,
                             input logic [7:0] d, input logic ef, output logic [2:0] st);
        int len;
        bit bad;
        if (bpos == 0) begin
            ferr = 0;
            fnew = 0;
            if (!cnt_ok(c, i)) ferr = fr_pkg::ST_BADCOUNT;
            else begin
                if (e_valid && age >= tmo) clear_entry();
                if (!e_valid) begin
                    clear_entry();
                    e_valid = 1; e_tok = t; e_cnt = c[4:0]; fnew = 1;
                end
                ferr = match_entry(t, i);
            end
        end else if (ferr == 0) begin
            ferr = cnt_ok(c, i) ? match_entry(t, i) : fr_pkg::ST_BADCOUNT;
        end
        if (ferr == 0 && bpos < SLOT && i * SLOT + bpos < BUFN) mbuf[i * SLOT + bpos] = d;
        if (!ef) begin
            st = ferr != 0 ? ferr : fr_pkg::ST_TAKEN;
            if (bpos < 255) bpos++;
            return;
        end
        len = bpos + 1;
        bad = len > SLOT || (len != SLOT && i + 1 != c);
        if (ferr == fr_pkg::ST_BADCOUNT) st = fr_pkg::ST_BADCOUNT;
        else if (bad) begin
            st = fr_pkg::ST_BADLEN;
            if (fnew) clear_entry();
        end else if (ferr != 0) st = ferr;
        else begin
            rx_mask[i] = 1;
            rx_cnt++;
            c_len = c_len + 12'(len);
            st = fr_pkg::ST_DONE;
        end
        bpos = 0; ferr = 0; fnew = 0;
    endtask

    always @(posedge clk or negedge rst_n) begin
        reply_t r, got;
        if (!rst_n) begin
            tmo = fr_pkg::TIMEOUT_RESET;
            clear_entry();
            bpos = 0; ferr = 0; fnew = 0;
            replies_q.delete();
            err_count = 0;
            n_results = 0;
            pending = 0;
        end else begin
            if (cfg_valid && cfg_ready) tmo = cfg_data;
            if (in_valid && !in_stall) begin
                r = '0;
                r.st = fr_pkg::ST_DONE;
                case (fr_pkg::cmd_t'(command))
                    fr_pkg::CMD_FRAG: frag_byte(token, frag_count, frag_index, data_byte,
                                                end_of_frag, r.st);
                    fr_pkg::CMD_TICK: if (e_valid && age != 16'hFFFF) age++;
                    fr_pkg::CMD_READ: begin
                        if (!e_valid || token != e_tok) r.st = fr_pkg::ST_NOTOKEN;
                        else if (rx_cnt != e_cnt) r.st = fr_pkg::ST_INCOMPLETE;
                        else if (read_address >= c_len) r.st = fr_pkg::ST_BADLEN;
                        else r.rd = mbuf[read_address];
                    end
                    default: begin
                        if (e_valid && token == e_tok) clear_entry();
                        else r.st = fr_pkg::ST_NOTOKEN;
                    end
                endcase
                r.cmpl = e_valid && rx_cnt == e_cnt;
                r.act  = e_valid;
                r.tlen = e_valid ? c_len : 12'd0;
                r.tok  = e_valid ? e_tok : 8'd0;
                replies_q.push_back(r);
            end
            if (out_valid && !out_stall) begin
                n_results++;
                got = '{status, read_data, complete, entry_active, total_length, held_token};
                if (replies_q.size() == 0) report("unexpected result", 0, 0);
                else begin
                    r = replies_q.pop_front();
                    if (got.st != r.st) report("status", got.st, r.st);
                    if (got.rd != r.rd) report("read_data", got.rd, r.rd);
                    if (got.cmpl != r.cmpl) report("complete", got.cmpl, r.cmpl);
                    if (got.act != r.act) report("entry_active", got.act, r.act);
                    if (got.tlen != r.tlen) report("total_length", got.tlen, r.tlen);
                    if (got.tok != r.tok) report("held_token", got.tok, r.tok);
                end
            end
            pending = replies_q.size();
        end
    end
endmodule

// File: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [1:0]  command = 0;
    logic [7:0]  token = 0, frag_count = 0, frag_index = 0, data_byte = 0;
    logic        end_of_frag = 0;
    logic [11:0] read_address = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [2:0]  status;
    logic [7:0]  read_data, held_token;
    logic        complete, entry_active;
    logic [11:0] total_length;

    int err_count, pending, n_results;
    int n_items = 0;
    int n_msgs = 0;
    bit hold_long = 0;   // receiver held off for the backpressure phase

    always #4 clk = ~clk;

    fragment_reassembler_top u_dut (.*);

    fr_checker u_chk (.*);

    // receiver: random stalls, mostly short; long freeze on request
    initial begin
        int n;
        @(posedge rst_n);
        forever begin
            if (hold_long) begin
                out_stall <= 1;
                repeat (60) @(posedge clk);
                hold_long = 0;
            end
            n = $urandom_range(0, 9);
            if (n < 5) begin
                out_stall <= 0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end else begin
                out_stall <= 1;
                repeat (n == 9 ? $urandom_range(10, 30) : $urandom_range(1, 3)) @(posedge clk);
            end
        end
    end

    // one item: hold until accepted, then maybe idle
    task automatic send(input fr_pkg::cmd_t c, input logic [7:0] t, input logic [7:0] cnt,
                        input logic [7:0] idx, input logic [7:0] d, input logic ef,
                        input logic [11:0] a);
        int g;
        in_valid <= 1;
        command <= c; token <= t; frag_count <= cnt; frag_index <= idx;
        data_byte <= d; end_of_frag <= ef; read_address <= a;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        n_items++;
        g = $urandom_range(0, 19);
        if (g >= 12) begin
            in_valid <= 0;
            repeat (g == 19 ? $urandom_range(8, 25) : $urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // whole fragment of len bytes
    task automatic send_frag(input logic [7:0] t, input logic [7:0] cnt,
                             input logic [7:0] idx, input int len);
        for (int i = 0; i < len; i++)
            send(fr_pkg::CMD_FRAG, t, cnt, idx, 8'($urandom), i == len - 1, 12'($urandom));
    endtask

    // well-formed message, fragments shuffled, occasional dup/short fragment, tick or read
    task automatic send_msg(input logic [7:0] t, input int cnt);
        int order[$];
        int j;
        for (int i = 0; i < cnt; i++) order.push_back(i);
        order.shuffle();
        foreach (order[k]) begin
            j = order[k];
            send_frag(t, 8'(cnt), 8'(j), j == cnt - 1 ? $urandom_range(1, 153) : 153);
            if ($urandom_range(0, 9) == 0) send_frag(t, 8'(cnt), 8'(j), $urandom_range(1, 5));
            if ($urandom_range(0, 19) == 0) send(fr_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0);
            if ($urandom_range(0, 19) == 0)
                send(fr_pkg::CMD_READ, t, 0, 0, 0, 0, 12'($urandom));
        end
        repeat ($urandom_range(1, 5))
            send(fr_pkg::CMD_READ, t, 0, 0, 0, 0, 12'($urandom_range(0, 153 * cnt)));
        send(fr_pkg::CMD_READ, t, 0, 0, 0, 0, 12'hFFF);
        if ($urandom_range(0, 3) != 0) send(fr_pkg::CMD_RELEASE, t, 0, 0, 0, 0, 0);
        n_msgs++;
    endtask

    task automatic write_timeout(input logic [15:0] v);
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
    endtask

    initial begin
        int w;
        bit tmo_done;
        tmo_done = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: bad counts, bad index, a single-fragment message of one byte
        send(fr_pkg::CMD_READ, 8'h00, 0, 0, 0, 0, 0);
        send(fr_pkg::CMD_RELEASE, 8'hFF, 0, 0, 0, 0, 0);
        send(fr_pkg::CMD_FRAG, 8'h11, 0, 0, 8'hFF, 1, 0);
        send(fr_pkg::CMD_FRAG, 8'h11, 8'd17, 0, 8'h00, 1, 0);
        send(fr_pkg::CMD_FRAG, 8'h11, 8'hFF, 8'hFF, 8'hAA, 1, 12'hFFF);
        send(fr_pkg::CMD_FRAG, 8'h11, 8'd4, 8'd4, 8'h55, 1, 0);
        send_frag(8'h22, 1, 0, 1);
        send(fr_pkg::CMD_READ, 8'h22, 0, 0, 0, 0, 0);
        send(fr_pkg::CMD_READ, 8'h23, 0, 0, 0, 0, 0);
        send(fr_pkg::CMD_FRAG, 8'h33, 1, 0, 8'h01, 1, 0);   // pool full
        send(fr_pkg::CMD_FRAG, 8'h22, 1, 0, 8'h02, 1, 0);   // duplicate
        send(fr_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0);
        send(fr_pkg::CMD_RELEASE, 8'h22, 0, 0, 0, 0, 0);
        send(fr_pkg::CMD_FRAG, 8'h44, 2, 0, 8'h7F, 1, 0);   // short non-tail, new entry dropped
        send(fr_pkg::CMD_FRAG, 8'hFF, 16, 15, 8'h80, 1, 0); // tail of a 16-fragment message
        send(fr_pkg::CMD_READ, 8'hFF, 0, 0, 0, 0, 0);       // incomplete
        send(fr_pkg::CMD_RELEASE, 8'hFF, 0, 0, 0, 0, 0);

        // zero timeout expires anything held at the next fragment
        write_timeout(16'd0);
        send_frag(8'h5A, 2, 1, 3);
        send_frag(8'hA5, 1, 0, 2);
        send(fr_pkg::CMD_RELEASE, 8'hA5, 0, 0, 0, 0, 0);

        write_timeout(16'hFFFF);
        send_msg(8'h66, 2);

        // backpressure: freeze the receiver while items keep coming
        hold_long = 1;
        send_msg(8'h77, 1);

        while (n_items < 850) begin
            if (!tmo_done && n_items > 500) begin
                tmo_done = 1;
                write_timeout(16'($urandom_range(1, 3)));
                send_msg(8'($urandom), 2);
                repeat (4) send(fr_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0);
                send_frag(8'($urandom), 1, 0, 2);
                write_timeout(16'd1);
                send_frag(8'($urandom), 1, 0, 1);
            end
            w = $urandom_range(0, 9);
            if (w < 6) send_msg(8'($urandom), $urandom_range(1, 3));
            else if (w == 6) send_frag(8'($urandom), 8'($urandom), 8'($urandom),
                                       $urandom_range(1, 4));
            else if (w == 7) send(fr_pkg::cmd_t'($urandom_range(1, 3)), 8'($urandom),
                                  8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                                  12'($urandom));
            else if (w == 8) send_frag(8'($urandom), 2, 0, $urandom_range(150, 156));
            else send(fr_pkg::CMD_FRAG, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 1'($urandom), 12'($urandom));
        end

        write_timeout(16'd10000);
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Run covered %0d items and %0d well-formed messages, %0d results checked.",
                 n_items, n_msgs, n_results);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// File: fragment_reassembler_top.f
rtl/fr_pkg.sv
rtl/fr_front.sv
rtl/fr_back.sv
rtl/fragment_reassembler_top.sv
tb/fr_checker.sv
tb/tb_top.sv
